[src/lzcb_pkg.sv]
// ----------------------------------------------------------------------------
// lzcb_pkg
// Shared types and constants for the LZ control-byte decompressor.
// ----------------------------------------------------------------------------
package lzcb_pkg;

   // Default geometry, overridable on the top level.
   localparam int HISTORY_DEPTH_DEF  = 8192;
   localparam int PACKET_LEN_MAX_DEF = 65535;

   // Fixed field widths.
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 16;
   localparam int HS_W   = 3;
   localparam int OFFS_W = 12;
   // A copy position is at most a 12-bit offset plus header plus count.
   localparam int POS_W  = 13;
   // Copy length is the 4-bit count field plus two.
   localparam int CNT_W  = 5;
   localparam int SLOT_W = 3;

   localparam logic [CNT_W-1:0] COPY_BIAS  = 5'd2;
   localparam logic [3:0]       COUNT_MASK = 4'hf;
   localparam logic [LEN_W-1:0] IN_COUNT_SAT = 16'hffff;

   // Register indexes on the csr port.
   localparam logic [1:0] CSR_HEADER_SIZE       = 2'd0;
   localparam logic [1:0] CSR_COMPRESSED_MARKER = 2'd1;
   localparam logic [1:0] CSR_PLAIN_MARKER      = 2'd2;

   // Register reset values.
   localparam logic [HS_W-1:0]   HEADER_SIZE_RST = 3'd3;
   localparam logic [BYTE_W-1:0] COMP_MARKER_RST = 8'd4;
   localparam logic [BYTE_W-1:0] PLAIN_MARKER_RST = 8'd3;

   // Parsing phase of the packet being decoded.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PASS,
      PH_HEADER,
      PH_CTRL,
      PH_SLOT,
      PH_REF_HI,
      PH_DONE
   } ph_type;

   // Sequencer state.
   typedef enum logic [2:0] {
      S_IDLE,
      S_PROC,
      S_COPY_RD,
      S_COPY_WR,
      S_END
   } seq_type;

endpackage

[src/lz_control_byte_decompressor.sv]
// ----------------------------------------------------------------------------
// lz_control_byte_decompressor
// Packet decompressor for LZ77 streams with flag bytes: header rewrite,
// literals and back-references into a history memory, one status word per
// packet.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Contents
//  req_     in         tdata = {packet_length, in_byte}, tuser = first_byte,
//                      tlast = last_byte
//  rsp_     out        tdata = out_byte, tuser = {decode_ok, byte_valid},
//                      tlast = packet_done
//  csr_     in         write enable, register index, write data
//
//  An input word passes through accept, decode and end check; a
//  back-reference of up to 17 bytes adds a read step and a write step per
//  copied byte, because each byte is read from the history, then written.
//  The history is not cleared after reset: a per-packet fill count marks which
//  entries are valid, so the block is ready straight out of reset.
//  A stalled result channel holds the sequencer in its current step.
// ----------------------------------------------------------------------------
module lz_control_byte_decompressor
   import lzcb_pkg::*;
#(
   parameter int HISTORY_DEPTH  = HISTORY_DEPTH_DEF,
   parameter int PACKET_LEN_MAX = PACKET_LEN_MAX_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // in_byte [7:0], packet_length [23:8]
   input  logic [23:0]             req_tdata,
   // first_byte [0]
   input  logic                    req_tuser,
   input  logic                    req_tlast,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // out_byte [7:0]
   output logic [7:0]              rsp_tdata,
   // byte_valid [0], decode_ok [1]
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [7:0]              csr_wdata
);

   localparam int AW  = $clog2(HISTORY_DEPTH);
   localparam int OCW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [OCW-1:0]   DEPTH_OC = OCW'(HISTORY_DEPTH);
   localparam logic [LEN_W-1:0] LEN_CAP  = LEN_W'(PACKET_LEN_MAX);

   // History memory.
   logic [BYTE_W-1:0] hist_mem [HISTORY_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [AW-1:0]     rd_addr;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;

   // Sequencer and decode state.
   seq_type           state_ff, state_in;
   ph_type            phase_ff, phase_in;
   logic [OCW-1:0]    out_count_ff, out_count_in;
   logic [LEN_W-1:0]  in_count_ff, in_count_in;
   logic [BYTE_W-1:0] flag_ff, flag_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [BYTE_W-1:0] low_ff, low_in;
   logic              ok_ff, ok_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Configuration.
   logic [HS_W-1:0]   hs_ff;
   logic [BYTE_W-1:0] cm_ff;
   logic [BYTE_W-1:0] pm_ff;

   // Latched input word.
   logic [BYTE_W-1:0] b_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              first_ff;
   logic              last_ff;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_bv_ff, rsp_bv_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_ok_ff, rsp_ok_in;

   // Combinational helpers.
   logic              out_free;
   logic              emit_en;
   logic [BYTE_W-1:0] emit_byte;
   logic              emit_bv;
   logic              emit_done;
   logic              emit_ok;
   logic              store_en;
   logic [BYTE_W-1:0] store_byte;
   logic              clear_oc;
   logic [OCW-1:0]    oc_base;
   logic [LEN_W-1:0]  len_eff;
   logic [LEN_W-1:0]  in_count_next;
   logic              end_cond;
   logic [OFFS_W-1:0] offs;

   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rd_addr    = AW'(pos_ff - POS_W'(1));
   assign offs       = {b_ff, low_ff[7:4]};

   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_ok_ff, rsp_bv_ff};
   assign rsp_tlast  = rsp_done_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_CAP) begin
         len_eff = LEN_CAP;
      end else begin
         len_eff = len_ff;
      end
      in_count_next = (in_count_ff == IN_COUNT_SAT) ? in_count_ff : in_count_ff + LEN_W'(1);
      end_cond      = last_ff || (in_count_next >= len_eff);
   end

   // Sequencer: next state, decode actions and output loading.
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      in_count_in = in_count_ff;
      flag_in    = flag_ff;
      slot_in    = slot_ff;
      low_in     = low_ff;
      ok_in      = ok_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      emit_en    = 1'b0;
      emit_byte  = '0;
      emit_bv    = 1'b1;
      emit_done  = 1'b0;
      emit_ok    = 1'b0;
      store_en   = 1'b0;
      store_byte = '0;
      clear_oc   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_PROC;
            end
         end

         S_PROC: begin
            if (out_free) begin
               state_in = S_END;
               if (first_ff) begin
                  clear_oc    = 1'b1;
                  in_count_in = '0;
                  ok_in       = 1'b1;
                  flag_in     = '0;
                  slot_in     = '0;
                  low_in      = '0;
                  emit_en     = 1'b1;
                  if (b_ff != cm_ff) begin
                     phase_in  = PH_PASS;
                     emit_byte = b_ff;
                  end else if (hs_ff == '0 || len_eff < LEN_W'(hs_ff)) begin
                     ok_in     = 1'b0;
                     phase_in  = PH_PASS;
                     emit_byte = b_ff;
                  end else begin
                     emit_byte  = pm_ff;
                     store_en   = 1'b1;
                     store_byte = pm_ff;
                     phase_in   = (hs_ff == HS_W'(1)) ? PH_CTRL : PH_HEADER;
                  end
               end else begin
                  case (phase_ff)
                     PH_PASS: begin
                        emit_en   = 1'b1;
                        emit_byte = b_ff;
                     end
                     PH_HEADER: begin
                        emit_en    = 1'b1;
                        emit_byte  = b_ff;
                        store_en   = 1'b1;
                        store_byte = b_ff;
                        if ({1'b0, in_count_ff} + 17'd1 >= 17'(hs_ff)) begin
                           phase_in = PH_CTRL;
                        end
                     end
                     PH_CTRL: begin
                        flag_in  = b_ff;
                        slot_in  = '0;
                        phase_in = PH_SLOT;
                     end
                     PH_SLOT: begin
                        if (!flag_ff[slot_ff]) begin
                           emit_en    = 1'b1;
                           emit_byte  = b_ff;
                           store_en   = 1'b1;
                           store_byte = b_ff;
                           slot_in    = slot_ff + SLOT_W'(1);
                           phase_in   = (slot_ff == '1) ? PH_CTRL : PH_SLOT;
                        end else begin
                           low_in   = b_ff;
                           phase_in = PH_REF_HI;
                        end
                     end
                     PH_REF_HI: begin
                        if (offs == '0) begin
                           phase_in = PH_DONE;
                        end else begin
                           pos_in   = POS_W'(offs) + POS_W'(hs_ff);
                           cnt_in   = CNT_W'(low_ff[3:0] & COUNT_MASK) + COPY_BIAS;
                           state_in = S_COPY_RD;
                        end
                     end
                     PH_DONE: begin
                     end
                     default: begin
                        // A stray word outside any packet leaves no trace.
                        state_in = S_IDLE;
                     end
                  endcase
               end
            end
         end

         S_COPY_RD: begin
            state_in = S_COPY_WR;
         end

         S_COPY_WR: begin
            if (out_free) begin
               emit_en    = 1'b1;
               store_en   = 1'b1;
               // Positions not yet written in this packet read as zero.
               if (OCW'(pos_ff) <= out_count_ff) begin
                  emit_byte  = rd_data_ff;
                  store_byte = rd_data_ff;
               end
               pos_in = pos_ff + POS_W'(1);
               cnt_in = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  slot_in  = slot_ff + SLOT_W'(1);
                  phase_in = (slot_ff == '1) ? PH_CTRL : PH_SLOT;
                  state_in = S_END;
               end else begin
                  state_in = S_COPY_RD;
               end
            end
         end

         S_END: begin
            if (!end_cond) begin
               in_count_in = in_count_next;
               state_in    = S_IDLE;
            end else if (out_free) begin
               in_count_in = in_count_next;
               emit_en     = 1'b1;
               emit_bv     = 1'b0;
               emit_done   = 1'b1;
               emit_ok     = ok_ff && !(phase_ff == PH_HEADER || phase_ff == PH_SLOT ||
                                        phase_ff == PH_REF_HI);
               ok_in       = emit_ok;
               phase_in    = PH_IDLE;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // History write and fill count; bytes past the depth are not kept.
   always_comb begin
      oc_base      = clear_oc ? '0 : out_count_ff;
      mem_we       = store_en && (oc_base < DEPTH_OC);
      mem_waddr    = oc_base[AW-1:0];
      mem_wdata    = store_byte;
      out_count_in = mem_we ? oc_base + OCW'(1) : oc_base;
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bv_in    = rsp_bv_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_bv_in    = emit_bv;
         rsp_done_in  = emit_done;
         rsp_ok_in    = emit_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         out_count_ff <= '0;
         in_count_ff  <= '0;
         flag_ff      <= '0;
         slot_ff      <= '0;
         low_ff       <= '0;
         ok_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         out_count_ff <= out_count_in;
         in_count_ff  <= in_count_in;
         flag_ff      <= flag_in;
         slot_ff      <= slot_in;
         low_ff       <= low_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff <= HEADER_SIZE_RST;
         cm_ff <= COMP_MARKER_RST;
         pm_ff <= PLAIN_MARKER_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER_SIZE:       hs_ff <= csr_wdata[HS_W-1:0];
            CSR_COMPRESSED_MARKER: cm_ff <= csr_wdata;
            CSR_PLAIN_MARKER:      pm_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      cnt_ff      <= cnt_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_bv_ff   <= rsp_bv_in;
      rsp_done_ff <= rsp_done_in;
      rsp_ok_ff   <= rsp_ok_in;
      if (req_tvalid && req_tready) begin
         b_ff     <= req_tdata[7:0];
         len_ff   <= req_tdata[23:8];
         first_ff <= req_tuser;
         last_ff  <= req_tlast;
      end
   end

endmodule

[test/tb_lz_control_byte_decompressor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz_control_byte_decompressor
// Self-checking bench for the LZ control-byte decompressor. Packets are
// queued as byte words and streamed in with random gaps. Each accepted word
// is run through a behavioural decoder in the bench, and the resulting bytes
// and status words are checked against the response stream, which is
// throttled at random. The run covers several register settings, truncated
// and abandoned packets.
// ----------------------------------------------------------------------------
module tb_lz_control_byte_decompressor;
   import lzcb_pkg::*;

   localparam int HIST_DEPTH     = HISTORY_DEPTH_DEF;
   localparam int SLOTS_PER_CTRL = 8;
   localparam int LIMIT_CYCLES   = 1000000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 64;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      logic [7:0]  data;
      logic [15:0] len;
      logic        first;
      logic        last;
   } req_word_type;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       done;
      logic       ok;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   // Register copies used by the decoder and by the packet builder.
   logic [2:0]  cfg_hdr_size     = HEADER_SIZE_RST;
   logic [7:0]  cfg_comp_marker  = COMP_MARKER_RST;
   logic [7:0]  cfg_plain_marker = PLAIN_MARKER_RST;

   // Decoder state.
   logic [7:0]  hist_mem [0:HIST_DEPTH-1];
   int unsigned hist_fill;
   int unsigned byte_count;
   ph_type      parse_phase;
   logic [7:0]  ctrl_bits;
   int unsigned slot_no;
   logic [7:0]  ref_low;
   logic        pkt_ok;

   req_word_type pending_words [$];
   rsp_word_type expected_out [$];
   logic [7:0]   pkt [$];

   req_word_type cur_word;
   int          tx_gap;
   int          rx_stall;
   int          hold_left;
   bit          hold_req;
   bit          hold_taken;
   bit          tx_quiet;
   bit          rx_quiet;
   bit          pkt_open;
   int          fail_count;
   int          reports;
   int          cycle_count;

   lz_control_byte_decompressor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Behavioural decoder
   // ------------------------------------------------------------------------
   function automatic void expect_word(logic [7:0] b, logic v, logic d, logic ok);
      rsp_word_type w;
      w.data  = b;
      w.valid = v;
      w.done  = d;
      w.ok    = ok;
      expected_out = {expected_out, w};
   endfunction

   function automatic void store_out(logic [7:0] b);
      // Bytes past the end of the history still go out but are not kept.
      if (hist_fill < HIST_DEPTH) begin
         hist_mem[hist_fill] = b;
         hist_fill++;
      end
      expect_word(b, 1'b1, 1'b0, 1'b0);
   endfunction

   function automatic void advance_slot();
      slot_no++;
      if (slot_no >= SLOTS_PER_CTRL) begin
         slot_no     = 0;
         parse_phase = PH_CTRL;
      end else begin
         parse_phase = PH_SLOT;
      end
   endfunction

   function automatic void clear_decoder();
      for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = '0;
      hist_fill   = 0;
      byte_count  = 0;
      parse_phase = PH_IDLE;
      ctrl_bits   = '0;
      slot_no     = 0;
      ref_low     = '0;
      pkt_ok      = 1'b1;
   endfunction

   function automatic void decode_word(req_word_type w);
      int unsigned hs;
      int unsigned plen;
      int unsigned ref_word;
      int unsigned offs;
      int unsigned cnt;
      int unsigned pos;
      logic [7:0]  v;
      hs   = 32'(cfg_hdr_size);
      plen = (w.len == 0) ? 1 : 32'(w.len);
      // A stray word outside any packet leaves no trace at all.
      if (!w.first && parse_phase == PH_IDLE) return;
      if (w.first) begin
         hist_fill  = 0;
         byte_count = 0;
         pkt_ok     = 1'b1;
         ctrl_bits  = '0;
         slot_no    = 0;
         ref_low    = '0;
         if (w.data != cfg_comp_marker) begin
            parse_phase = PH_PASS;
            expect_word(w.data, 1'b1, 1'b0, 1'b0);
         end else if (hs == 0 || plen < hs) begin
            pkt_ok      = 1'b0;
            parse_phase = PH_PASS;
            expect_word(w.data, 1'b1, 1'b0, 1'b0);
         end else begin
            store_out(cfg_plain_marker);
            parse_phase = (hs == 1) ? PH_CTRL : PH_HEADER;
         end
      end else begin
         case (parse_phase)
            PH_PASS: begin
               expect_word(w.data, 1'b1, 1'b0, 1'b0);
            end
            PH_HEADER: begin
               store_out(w.data);
               if (byte_count + 1 >= hs) parse_phase = PH_CTRL;
            end
            PH_CTRL: begin
               ctrl_bits   = w.data;
               slot_no     = 0;
               parse_phase = PH_SLOT;
            end
            PH_SLOT: begin
               if (!ctrl_bits[slot_no]) begin
                  store_out(w.data);
                  advance_slot();
               end else begin
                  ref_low     = w.data;
                  parse_phase = PH_REF_HI;
               end
            end
            PH_REF_HI: begin
               ref_word = 32'({w.data, ref_low});
               offs     = ref_word >> 4;
               if (offs == 0) begin
                  parse_phase = PH_DONE;
               end else begin
                  cnt = (ref_word & 32'(COUNT_MASK)) + 32'(COPY_BIAS);
                  // Positions are one-based; unwritten ones read as zero.
                  for (int k = 0; k < cnt; k++) begin
                     pos = offs + hs + k;
                     v   = '0;
                     if (pos <= hist_fill && pos - 1 < HIST_DEPTH) v = hist_mem[pos - 1];
                     store_out(v);
                  end
                  advance_slot();
               end
            end
            default: begin
            end
         endcase
      end
      if (byte_count < IN_COUNT_SAT) byte_count++;
      if (w.last || byte_count >= plen) begin
         if (parse_phase == PH_HEADER || parse_phase == PH_SLOT || parse_phase == PH_REF_HI)
            pkt_ok = 1'b0;
         expect_word('0, 1'b0, 1'b1, pkt_ok);
         parse_phase = PH_IDLE;
      end
   endfunction

   function automatic void check_result(rsp_word_type got);
      rsp_word_type want;
      if (expected_out.size() == 0) begin
         fail_count++;
         if (reports < MAX_REPORTS) begin
            $display("%0t: unexpected result byte %02h valid %0b done %0b ok %0b",
                     $realtime, got.data, got.valid, got.done, got.ok);
            reports++;
         end
         return;
      end
      want = expected_out.pop_front();
      if (got.data !== want.data || got.valid !== want.valid ||
          got.done !== want.done || got.ok !== want.ok) begin
         fail_count++;
         if (reports < MAX_REPORTS) begin
            $display("%0t: mismatch: expected byte %02h valid %0b done %0b ok %0b", $realtime,
                     want.data, want.valid, want.done, want.ok);
            $display("%0t:           got byte %02h valid %0b done %0b ok %0b", $realtime,
                     got.data, got.valid, got.done, got.ok);
            reports++;
         end
      end
   endfunction

   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 15);
      if (r < 9) return 0;
      if (r < 14) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   // ------------------------------------------------------------------------
   // Input driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) decode_word(cur_word);
         if (tx_gap != 0) begin
            tx_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            cur_word = pending_words.pop_front();
            req_tdata  <= {cur_word.len, cur_word.data};
            req_tuser  <= cur_word.first;
            req_tlast  <= cur_word.last;
            req_tvalid <= 1'b1;
            tx_gap = pick_gap(tx_quiet);
            if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor and back-pressure
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_stall  = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result({rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]});
            rx_stall = pick_gap(rx_quiet);
            if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;
         end
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_stall != 0) begin
            rx_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_lz_control_byte_decompressor: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Packet building
   // ------------------------------------------------------------------------
   function automatic void push_word(logic [7:0] b, logic [15:0] len, bit first, bit last);
      req_word_type w;
      w.data  = b;
      w.len   = len;
      w.first = first;
      w.last  = last;
      pending_words = {pending_words, w};
   endfunction

   function automatic void add_pkt_byte(logic [7:0] b);
      pkt = {pkt, b};
   endfunction

   function automatic int push_pkt(logic [15:0] len, bit with_last);
      for (int i = 0; i < pkt.size(); i++)
         push_word(pkt[i], len, i == 0, with_last && i == pkt.size() - 1);
      return pkt.size();
   endfunction

   function automatic logic [7:0] other_than_marker();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == cfg_comp_marker) b = ~b;
      return b;
   endfunction

   // Well-formed compressed body; refs mostly point at bytes already out.
   function automatic void build_lz(int nblocks, bit may_end, bit all_refs);
      int unsigned hs;
      int unsigned produced;
      int unsigned offs;
      int unsigned span;
      logic [7:0]  ctrl;
      logic [3:0]  nib;
      logic [15:0] ref_word;
      hs = 32'(cfg_hdr_size);
      pkt.delete();
      add_pkt_byte(cfg_comp_marker);
      for (int i = 1; i < hs; i++) add_pkt_byte(8'($urandom));
      produced = hs;
      for (int blk = 0; blk < nblocks; blk++) begin
         if (all_refs) ctrl = 8'hff;
         else if ($urandom_range(0, 3) == 0) ctrl = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
         else ctrl = 8'($urandom);
         add_pkt_byte(ctrl);
         for (int s = 0; s < SLOTS_PER_CTRL; s++) begin
            if (!ctrl[s]) begin
               add_pkt_byte(8'($urandom));
               produced++;
            end else begin
               span = (produced > hs) ? produced - hs : 1;
               if (span > 4095) span = 4095;
               if (may_end && $urandom_range(0, 19) == 0) offs = 0;
               else if ($urandom_range(0, 5) != 0) offs = $urandom_range(1, span);
               else offs = $urandom_range(1, 4095);
               nib = all_refs ? 4'hf : 4'($urandom);
               ref_word = {offs[11:0], nib};
               add_pkt_byte(ref_word[7:0]);
               add_pkt_byte(ref_word[15:8]);
               if (offs == 0) begin
                  // Whatever follows the end marker is skipped by the block.
                  repeat ($urandom_range(0, 3)) add_pkt_byte(8'($urandom));
                  return;
               end
               produced += nib + 2;
            end
         end
      end
   endfunction

   function automatic int queue_random_packet();
      int r;
      int unsigned hs;
      int unsigned sz;
      hs = 32'(cfg_hdr_size);
      r  = $urandom_range(0, 99);
      if (r < 55) begin
         build_lz($urandom_range(0, 3), 1'b1, 1'b0);
         sz = pkt.size();
         case ($urandom_range(0, 3))
            0, 1:    r = push_pkt(16'(sz), 1'b1);
            2:       r = push_pkt(16'(sz), 1'b0);
            default: r = push_pkt(16'($urandom_range(sz, 65535)), 1'b1);
         endcase
      end else if (r < 67) begin
         build_lz($urandom_range(1, 3), 1'b0, 1'b0);
         sz = $urandom_range(1, pkt.size() - 1);
         while (pkt.size() > sz) void'(pkt.pop_back());
         r = push_pkt(16'(sz), 1'b1);
      end else if (r < 79 || (r < 85 && hs < 2)) begin
         pkt.delete();
         add_pkt_byte(other_than_marker());
         repeat ($urandom_range(0, 7)) add_pkt_byte(8'($urandom));
         r = push_pkt(16'(pkt.size()), 1'($urandom_range(0, 1)));
      end else if (r < 85) begin
         // Compressed marker but shorter than the header.
         pkt.delete();
         add_pkt_byte(cfg_comp_marker);
         sz = $urandom_range(1, hs - 1);
         while (pkt.size() < sz) add_pkt_byte(8'($urandom));
         r = push_pkt(16'(sz), 1'($urandom_range(0, 1)));
      end else if (r < 91) begin
         // Cut short with no end mark; the next packet start abandons it.
         build_lz(1, 1'b0, 1'b0);
         sz = $urandom_range(1, pkt.size());
         while (pkt.size() > sz) void'(pkt.pop_back());
         r = push_pkt(16'hffff, 1'b0);
         pkt_open = 1'b1;
         return r;
      end else if (r < 95 && !pkt_open) begin
         repeat ($urandom_range(1, 3))
            push_word(8'($urandom), 16'($urandom), 1'b0, 1'($urandom_range(0, 1)));
         r = 0;
      end else begin
         pkt.delete();
         add_pkt_byte(($urandom_range(0, 1) != 0) ? cfg_comp_marker : other_than_marker());
         if ($urandom_range(0, 1) != 0) begin
            r = push_pkt(16'h0000, 1'b0);
         end else begin
            repeat ($urandom_range(1, 6)) add_pkt_byte(8'($urandom));
            r = push_pkt(16'hffff, 1'b1);
         end
      end
      pkt_open = 1'b0;
      return r;
   endfunction

   function automatic void queue_random(int target);
      int queued;
      queued = 0;
      while (queued < target) queued += queue_random_packet();
      // Close the phase with a complete packet so the block ends up idle.
      build_lz($urandom_range(1, 2), 1'b0, 1'b0);
      void'(push_pkt(16'(pkt.size()), 1'b1));
      pkt_open = 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Sequencing
   // ------------------------------------------------------------------------
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_tvalid || expected_out.size() != 0)
         @(posedge clock);
      // Words that produce nothing may still be in flight.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_HEADER_SIZE:       cfg_hdr_size     = val[2:0];
         CSR_COMPRESSED_MARKER: cfg_comp_marker  = val;
         CSR_PLAIN_MARKER:      cfg_plain_marker = val;
         default: begin
         end
      endcase
   endtask

   task automatic set_config(logic [2:0] hs, logic [7:0] cm, logic [7:0] pm);
      wait_idle();
      write_reg(CSR_HEADER_SIZE, {5'b0, hs});
      write_reg(CSR_COMPRESSED_MARKER, cm);
      write_reg(CSR_PLAIN_MARKER, pm);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      clear_decoder();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset register values: header 3, markers 4 and 3.
      push_word(8'h00, 16'd2, 1'b1, 1'b0);
      push_word(8'hff, 16'd2, 1'b0, 1'b1);
      // Literal, overlapping 17-byte copy, copy from unwritten positions,
      // end marker and a skipped trailing byte.
      pkt = '{8'h04, 8'hff, 8'h00, 8'h0e, 8'ha5, 8'h1f, 8'h00, 8'hf0, 8'hff,
              8'h00, 8'h00, 8'h77};
      void'(push_pkt(16'd12, 1'b1));
      // Compressed marker on a packet shorter than the header, ended by count.
      push_word(8'h04, 16'd2, 1'b1, 1'b0);
      push_word(8'h11, 16'd2, 1'b0, 1'b0);
      // Stray word outside a packet.
      push_word(8'h55, 16'd1, 1'b0, 1'b1);
      // Ends inside the header.
      push_word(8'h04, 16'd5, 1'b1, 1'b0);
      push_word(8'h12, 16'd5, 1'b0, 1'b1);
      // An open packet abandoned by a new start of length zero.
      push_word(8'h09, 16'd4, 1'b1, 1'b0);
      push_word(8'h33, 16'd0, 1'b1, 1'b0);
      // Ends right after the header.
      pkt = '{8'h04, 8'h01, 8'h02};
      void'(push_pkt(16'd3, 1'b1));
      queue_random(30);

      set_config(3'd1, 8'h00, 8'hff);
      queue_random(30);
      // Hold the result side off while input keeps arriving.
      hold_req = 1'b1;

      set_config(3'd7, 8'hff, 8'h00);
      queue_random(30);

      set_config(3'd3, 8'h4c, 8'hb3);
      queue_random(20);

      set_config(3'($urandom_range(1, 7)), 8'($urandom), 8'($urandom));
      queue_random(30);

      set_config(3'd2, 8'($urandom), 8'($urandom));
      queue_random(20);

      wait_idle();
      fail_count += expected_out.size();
      if (fail_count == 0) begin
         $display("tb_lz_control_byte_decompressor: PASS");
      end else begin
         $display("tb_lz_control_byte_decompressor: FAIL");
      end
      $finish;
   end

endmodule
